>>> rtl/core/arqs_pkg.sv
package arqs_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF  = 16;
  localparam int unsigned TASK_ID_BITS_DEF = 8;

  localparam logic [1:0] AFFINITY_ANY = 2'd3;

  typedef enum logic [1:0] {
    CMD_ENQUEUE  = 2'd0,
    CMD_SCHEDULE = 2'd1,
    CMD_REMOVE   = 2'd2
  } arqs_cmd_t;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_IDLE   = 2'd1,
    STS_FULL   = 2'd2,
    STS_ABSENT = 2'd3
  } arqs_status_t;

endpackage

>>> rtl/core/affinity_ready_queue_scheduler_core.sv
// Flow: enqueue and the unused command register their result in the dispatch state after the
// input beat. Schedule and remove scan the ring buffer entry by entry (a read state, then a
// check state), then move entries with one read state and one write state each (skipped
// entries for schedule, later entries for remove) before the result is registered.
// One item at a time; the next input beat can land in the cycle that the result is taken.
// The entry memory and its registered read set the pace.
// Reset empties the queue (count and head pointer cleared); entry storage keeps its
// contents and is never read unless written.
module affinity_ready_queue_scheduler_core
  import arqs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int unsigned TASK_ID_BITS = TASK_ID_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_command,
  input  logic [TASK_ID_BITS-1:0]              in_task_id,
  input  logic [1:0]                           in_task_mask,
  input  logic                                 in_cpu_index,
  input  logic                                 in_still_runnable,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [TASK_ID_BITS-1:0]              out_chosen_task,
  output logic [1:0]                           out_status,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]     out_queue_count
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW = CW + 1;
  localparam int unsigned EW = TASK_ID_BITS + 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_COPY_RD,
    S_COPY_WR
  } state_t;

  state_t                  state_r;
  arqs_cmd_t               cmd_r;
  logic [TASK_ID_BITS-1:0] id_r;
  logic [1:0]              mask_r;
  logic                    cpu_r;
  logic                    run_r;
  logic                    drop_r;
  logic [AW-1:0]           head_r;
  logic [CW-1:0]           count_r;
  logic [CW-1:0]           idx_r;
  logic [AW-1:0]           scan_ptr_r;
  logic [AW-1:0]           src_r;
  logic [AW-1:0]           dst_r;
  logic [CW-1:0]           rem_r;
  logic [TASK_ID_BITS-1:0] pick_r;
  logic                    out_valid_r;
  logic [TASK_ID_BITS-1:0] out_chosen_r;
  arqs_status_t            out_status_r;
  logic [CW-1:0]           out_count_r;

  logic [EW-1:0]           mem [QUEUE_DEPTH];
  logic [EW-1:0]           rdata_r;
  logic [AW-1:0]           rd_addr;
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [EW-1:0]           mem_wdata;

  logic                    full;
  logic                    push_req;
  logic [AW-1:0]           tail;
  logic [TASK_ID_BITS-1:0] rd_id;
  logic [1:0]              rd_aff;
  logic                    hit;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] p, input logic [CW-1:0] k);
    logic [SW-1:0] s;
    s = SW'(p) + SW'(k);
    if (s >= SW'(QUEUE_DEPTH)) begin
      s = s - SW'(QUEUE_DEPTH);
    end
    ptr_add = s[AW-1:0];
  endfunction

  assign full     = (count_r == CW'(QUEUE_DEPTH));
  assign tail     = ptr_add(head_r, count_r);
  assign push_req = (cmd_r == CMD_ENQUEUE) ||
                    ((cmd_r == CMD_SCHEDULE) && run_r && (id_r != '0));
  assign rd_id    = rdata_r[TASK_ID_BITS-1:0];
  assign rd_aff   = rdata_r[EW-1:TASK_ID_BITS];
  assign hit      = (cmd_r == CMD_SCHEDULE) ?
                    ((rd_aff == AFFINITY_ANY) || (rd_aff == {cpu_r, ~cpu_r})) :
                    (rd_id == id_r);

  assign in_ready        = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign out_valid       = out_valid_r;
  assign out_chosen_task = out_chosen_r;
  assign out_status      = out_status_r;
  assign out_queue_count = out_count_r;

  always_comb begin
    rd_addr   = (state_r == S_SCAN_RD) ? scan_ptr_r : src_r;
    mem_we    = 1'b0;
    mem_waddr = dst_r;
    mem_wdata = rdata_r;
    if (state_r == S_DISPATCH) begin
      mem_we    = push_req && !full;
      mem_waddr = tail;
      mem_wdata = {mask_r, id_r};
    end else if (state_r == S_COPY_WR) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cmd_r   <= arqs_cmd_t'(in_command);
            id_r    <= in_task_id;
            mask_r  <= in_task_mask;
            cpu_r   <= in_cpu_index;
            run_r   <= in_still_runnable;
            drop_r  <= 1'b0;
            state_r <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          idx_r      <= '0;
          scan_ptr_r <= head_r;
          if (push_req) begin
            if (full) begin
              drop_r <= 1'b1;
            end else begin
              count_r <= count_r + CW'(1);
            end
          end
          unique case (cmd_r) inside
            CMD_ENQUEUE: begin
              out_valid_r  <= 1'b1;
              out_chosen_r <= '0;
              out_status_r <= full ? STS_FULL : STS_OK;
              out_count_r  <= full ? count_r : count_r + CW'(1);
              state_r      <= S_IDLE;
            end
            CMD_SCHEDULE, CMD_REMOVE: begin
              state_r <= S_SCAN_RD;
            end
            default: begin
              out_valid_r  <= 1'b1;
              out_chosen_r <= '0;
              out_status_r <= STS_OK;
              out_count_r  <= count_r;
              state_r      <= S_IDLE;
            end
          endcase
        end
        S_SCAN_RD: begin
          if (idx_r == count_r) begin
            // no match: order stays as it is
            out_valid_r  <= 1'b1;
            out_chosen_r <= '0;
            out_count_r  <= count_r;
            if (cmd_r == CMD_SCHEDULE) begin
              out_status_r <= drop_r ? STS_FULL : STS_IDLE;
            end else begin
              out_status_r <= STS_ABSENT;
            end
            state_r <= S_IDLE;
          end else begin
            state_r <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          if (hit) begin
            if (cmd_r == CMD_SCHEDULE) begin
              // skipped entries go to the back, head moves past the picked slot
              pick_r <= rd_id;
              src_r  <= head_r;
              dst_r  <= tail;
              rem_r  <= idx_r;
            end else begin
              // close the gap: later entries move down by one
              pick_r <= '0;
              dst_r  <= scan_ptr_r;
              src_r  <= ptr_inc(scan_ptr_r);
              rem_r  <= count_r - CW'(1) - idx_r;
            end
            state_r <= S_COPY_RD;
          end else begin
            idx_r      <= idx_r + CW'(1);
            scan_ptr_r <= ptr_inc(scan_ptr_r);
            state_r    <= S_SCAN_RD;
          end
        end
        S_COPY_RD: begin
          if (rem_r == '0) begin
            count_r <= count_r - CW'(1);
            if (cmd_r == CMD_SCHEDULE) begin
              head_r <= ptr_inc(src_r);
            end
            out_valid_r  <= 1'b1;
            out_chosen_r <= pick_r;
            out_status_r <= drop_r ? STS_FULL : STS_OK;
            out_count_r  <= count_r - CW'(1);
            state_r      <= S_IDLE;
          end else begin
            state_r <= S_COPY_WR;
          end
        end
        S_COPY_WR: begin
          src_r   <= ptr_inc(src_r);
          dst_r   <= ptr_inc(dst_r);
          rem_r   <= rem_r - CW'(1);
          state_r <= S_COPY_RD;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("queue occupancy above depth");

  a_copy_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COPY_RD || state_r == S_COPY_WR) |-> count_r != '0)
    else $error("entry move with empty queue");

  a_scan_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN_CHK) |-> idx_r < count_r)
    else $error("scan beyond occupied entries");

  a_accept_dispatch : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DISPATCH) && !out_valid_r)
    else $error("accepted beat not dispatched");

endmodule

>>> sim/arqs_tracker_pkg.sv
package arqs_tracker_pkg;

  import arqs_pkg::*;

  localparam int unsigned RQ_DEPTH = QUEUE_DEPTH_DEF;

  typedef struct packed {
    logic [7:0] id;
    logic [1:0] aff;
  } ready_entry_t;

  typedef struct packed {
    logic [7:0] chosen;
    logic [1:0] status;
    logic [4:0] count;
  } sched_result_t;

  class ready_queue_tracker;
    ready_entry_t  ready_q[$];
    sched_result_t awaited[$];
    logic [7:0]    running_id[2];
    logic [1:0]    running_aff[2];
    int unsigned   mismatches;

    function new();
      mismatches = 0;
      foreach (running_id[c]) begin
        running_id[c]  = '0;
        running_aff[c] = '0;
      end
    endfunction

    // Advance the ready queue by one accepted command and queue the result it should give.
    function void note_command(logic [1:0] cmd, logic [7:0] id, logic [1:0] mask,
                               logic cpu, logic run);
      sched_result_t r;
      ready_entry_t  e;
      ready_entry_t  rotated[$];
      int            pick;
      bit            dropped;
      r        = '0;
      r.status = STS_OK;
      e.id     = id;
      e.aff    = mask;
      case (cmd)
        CMD_ENQUEUE: begin
          if (ready_q.size() >= RQ_DEPTH) r.status = STS_FULL;
          else ready_q.push_back(e);
        end
        CMD_SCHEDULE: begin
          dropped = 1'b0;
          if (run && id != 8'd0) begin
            if (ready_q.size() >= RQ_DEPTH) dropped = 1'b1;
            else ready_q.push_back(e);
          end
          pick = -1;
          for (int i = 0; i < ready_q.size(); i++) begin
            if (ready_q[i].aff == AFFINITY_ANY || ready_q[i].aff == ({1'b0, cpu} + 2'd1)) begin
              pick = i;
              break;
            end
          end
          if (pick >= 0) begin
            r.chosen = ready_q[pick].id;
            running_aff[cpu] = ready_q[pick].aff;
            // skipped entries go behind the ones after the pick, order kept
            for (int k = pick + 1; k < ready_q.size(); k++) rotated.push_back(ready_q[k]);
            for (int k = 0; k < pick; k++) rotated.push_back(ready_q[k]);
            ready_q = rotated;
          end else begin
            r.status = STS_IDLE;
            running_aff[cpu] = '0;
          end
          if (dropped) r.status = STS_FULL;
          running_id[cpu] = r.chosen;
        end
        CMD_REMOVE: begin
          pick = -1;
          for (int i = 0; i < ready_q.size(); i++) begin
            if (ready_q[i].id == id) begin
              pick = i;
              break;
            end
          end
          if (pick >= 0) ready_q.delete(pick);
          else r.status = STS_ABSENT;
        end
        default: ;
      endcase
      r.count = 5'(ready_q.size());
      awaited.push_back(r);
    endfunction

    function logic [7:0] live_id();
      if (ready_q.size() == 0) return 8'($urandom_range(0, 255));
      return ready_q[$urandom_range(0, ready_q.size() - 1)].id;
    endfunction

    task report_mismatch(string what);
      if (mismatches < 100) $display("mismatch: %s", what);
      mismatches++;
    endtask

    task check_result(logic [7:0] chosen, logic [1:0] status, logic [4:0] count);
      sched_result_t want;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing outstanding: chosen=%0d status=%0d count=%0d",
                                  chosen, status, count));
        return;
      end
      want = awaited.pop_front();
      if (chosen !== want.chosen)
        report_mismatch($sformatf("chosen_task %0d, want %0d", chosen, want.chosen));
      if (status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", status, want.status));
      if (count !== want.count)
        report_mismatch($sformatf("queue_count %0d, want %0d", count, want.count));
    endtask
  endclass

endpackage

>>> sim/affinity_ready_queue_scheduler_core_test.sv
module affinity_ready_queue_scheduler_core_test;
  import arqs_pkg::*;
  import arqs_tracker_pkg::*;

  localparam logic [1:0]  CMD_UNUSED    = 2'd3;
  localparam int unsigned RANDOM_ITEMS  = 1200;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 120;
  localparam int unsigned QUIET_LIMIT   = 4000;

  logic       clk;
  logic       rst_n             = 1'b0;
  logic       in_valid          = 1'b0;
  logic       in_ready;
  logic [1:0] in_command        = CMD_ENQUEUE;
  logic [7:0] in_task_id        = '0;
  logic [1:0] in_task_mask      = '0;
  logic       in_cpu_index      = 1'b0;
  logic       in_still_runnable = 1'b0;
  logic       out_valid;
  logic       out_ready         = 1'b0;
  logic [7:0] out_chosen_task;
  logic [1:0] out_status;
  logic [4:0] out_queue_count;

  ready_queue_tracker tracker = new();
  bit          calm          = 1'b0;
  bit          sink_hold_req = 1'b0;
  int unsigned quiet_cycles  = 0;

  affinity_ready_queue_scheduler_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_task_id       (in_task_id),
    .in_task_mask     (in_task_mask),
    .in_cpu_index     (in_cpu_index),
    .in_still_runnable(in_still_runnable),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_chosen_task  (out_chosen_task),
    .out_status       (out_status),
    .out_queue_count  (out_queue_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random back-pressure, one long hold-off on request.
  initial begin : sink
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        hold_left     = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 34);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_result(out_chosen_task, out_status, out_queue_count);
    if (rst_n && in_valid && in_ready)
      tracker.note_command(in_command, in_task_id, in_task_mask, in_cpu_index, in_still_runnable);
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic offer_command(input logic [1:0] cmd, input logic [7:0] id,
                               input logic [1:0] mask, input logic cpu, input logic run);
    in_valid          <= 1'b1;
    in_command        <= cmd;
    in_task_id        <= id;
    in_task_mask      <= mask;
    in_cpu_index      <= cpu;
    in_still_runnable <= run;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 99) < 34) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Drop valid and hold until every outstanding result has been taken.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic offer_random(input int unsigned n);
    int unsigned phase;
    int unsigned roll;
    int unsigned enq_lim;
    int unsigned sched_lim;
    logic [1:0]  cmd;
    logic [7:0]  id;
    logic [1:0]  mask;
    logic        cpu;
    logic        run;
    phase     = (n / 80) % 3;
    enq_lim   = (phase == 0) ? 60 : (phase == 1) ? 20 : 40;
    sched_lim = (phase == 0) ? 80 : (phase == 1) ? 65 : 70;
    roll      = $urandom_range(0, 99);
    if (roll < enq_lim)        cmd = CMD_ENQUEUE;
    else if (roll < sched_lim) cmd = CMD_SCHEDULE;
    else if (roll < 95)        cmd = CMD_REMOVE;
    else                       cmd = CMD_UNUSED;
    roll = $urandom_range(0, 99);
    if (roll < 75)      id = 8'($urandom_range(1, 24));
    else if (roll < 90) id = 8'($urandom_range(0, 255));
    else                id = 8'd0;
    mask = 2'($urandom_range(0, 3));
    cpu  = 1'($urandom_range(0, 1));
    run  = ($urandom_range(0, 99) < 70);
    // hand back the task this core is running, as a real scheduler tick would
    if (cmd == CMD_SCHEDULE && $urandom_range(0, 99) < 60) begin
      id   = tracker.running_id[cpu];
      mask = tracker.running_aff[cpu];
    end
    if (cmd == CMD_REMOVE && $urandom_range(0, 99) < 65) id = tracker.live_id();
    offer_command(cmd, id, mask, cpu, run);
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer_command(CMD_SCHEDULE, 8'h00, 2'd3, 1'b0, 1'b1);
    offer_command(CMD_REMOVE,   8'h33, 2'd0, 1'b0, 1'b0);
    offer_command(CMD_UNUSED,   8'hFF, 2'd3, 1'b1, 1'b1);
    offer_command(CMD_ENQUEUE,  8'h55, 2'd1, 1'b0, 1'b0);
    offer_command(CMD_ENQUEUE,  8'hAA, 2'd2, 1'b1, 1'b0);
    offer_command(CMD_ENQUEUE,  8'hFF, 2'd3, 1'b0, 1'b0);
    offer_command(CMD_ENQUEUE,  8'h55, 2'd2, 1'b0, 1'b0);
    offer_command(CMD_SCHEDULE, 8'h00, 2'd0, 1'b1, 1'b0);
    offer_command(CMD_SCHEDULE, 8'h07, 2'd0, 1'b0, 1'b1);
    offer_command(CMD_REMOVE,   8'h55, 2'd0, 1'b0, 1'b0);
    offer_command(CMD_SCHEDULE, 8'h00, 2'd0, 1'b1, 1'b1);
    for (int k = 0; k < 14; k++)
      offer_command(CMD_ENQUEUE, 8'h80 | 8'(k * 9), 2'(k), 1'b0, 1'b0);
    offer_command(CMD_ENQUEUE,  8'h01, 2'd3, 1'b0, 1'b0);
    offer_command(CMD_SCHEDULE, 8'hC3, 2'd3, 1'b0, 1'b1);
    hold_until_drained();

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 300) sink_hold_req = 1'b1;
      calm = (n >= 500 && n < 700);
      if (n == 800) hold_until_drained();
      offer_random(n);
      sender_gap();
    end

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
